[sv/dagc_pkg.sv]
package dagc_pkg;

  // Graph store geometry
  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int NUM_W     = IDX_W + 1;
  localparam int CNT_W     = 6;

  // Command codes
  localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
  localparam logic [1:0] OP_LOAD_ORDER = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // Register map: index taken from the word address
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [NUM_W-1:0] NODE_COUNT_RST = NUM_W'(MAX_NODES);

  // One closure result from the engine, counts still to be formed
  typedef struct packed {
    logic                 vld;
    logic [IDX_W-1:0]     node;
    logic [MAX_NODES-1:0] parent;
    logic [MAX_NODES-1:0] ancestor;
    logic [MAX_NODES-1:0] descendant;
    logic                 last;
  } res_t;

  // Population count, saturated at the count field's maximum
  function automatic logic [CNT_W-1:0] sat_popcount(input logic [MAX_NODES-1:0] v);
    logic [3:0]  byte_cnt;
    logic [NUM_W-1:0] total;
    total = '0;
    for (int b = 0; b < MAX_NODES / 8; b++) begin
      byte_cnt = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt = byte_cnt + 4'(v[b*8+k]);
      end
      total = total + NUM_W'(byte_cnt);
    end
    if (total > NUM_W'((1 << CNT_W) - 1)) begin
      return {CNT_W{1'b1}};
    end
    return total[CNT_W-1:0];
  endfunction

endpackage

[sv/dagc_engine.sv]
module dagc_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_vld,
  input  logic [1:0]                      cmd_opcode,
  input  logic [dagc_pkg::IDX_W-1:0]      cmd_index,
  input  logic [dagc_pkg::MAX_NODES-1:0]  cmd_row_bits,
  input  logic [dagc_pkg::IDX_W-1:0]      cmd_ordered_node,
  input  logic [dagc_pkg::NUM_W-1:0]      node_num,
  output logic                            busy,
  output dagc_pkg::res_t                  res
);
  import dagc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PAR  = 7'b0000010,
    ST_POS  = 7'b0000100,
    ST_KEY  = 7'b0001000,
    ST_HEAD = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  // Memories
  logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
  logic [IDX_W-1:0]     topo_mem [MAX_NODES];
  logic [MAX_NODES-1:0] par_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] anc_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] desc_mem [MAX_NODES];

  logic [MAX_NODES-1:0] adj_rd, par_rd, anc_rd, desc_rd, set_rd;
  logic [IDX_W-1:0]     topo_rd;
  logic [IDX_W-1:0]     adj_ra, topo_ra, sel_ra;
  logic                 adj_we, topo_we, par_we, anc_we, desc_we;
  logic [IDX_W-1:0]     adj_wa, topo_wa, col_wa, anc_wa, desc_wa;
  logic [MAX_NODES-1:0] adj_wd, col_wd, anc_wd, desc_wd;
  logic [IDX_W-1:0]     topo_wd;

  // Sequencer state
  state_t               state_r, state_nxt;
  logic [NUM_W-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]     nm1_r, nm1_nxt;
  logic [MAX_NODES-1:0] mask_r, mask_nxt;
  logic                 bwd_r, bwd_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [MAX_NODES-1:0] pm_r, pm_nxt;
  logic [MAX_NODES-1:0] acc_r, acc_nxt;
  logic                 d_vld_r, d_vld_nxt;
  logic [IDX_W-1:0]     d_i_r, d_i_nxt;
  logic [IDX_W-1:0]     d_j_r, d_j_nxt;
  logic                 o_vld_r, o_vld_nxt;
  logic [IDX_W-1:0]     o_j_r, o_j_nxt;
  logic                 o_last_r, o_last_nxt;

  // Walk advance
  state_t               adv_state;
  logic [IDX_W-1:0]     adv_pos;
  logic                 adv_bwd;

  logic [MAX_NODES-1:0] col_nxt, scan_acc;

  assign set_rd   = bwd_r ? desc_rd : anc_rd;
  assign scan_acc = acc_r | (pm_r[i_r] ? set_rd : '0);
  assign col_nxt  = ((d_i_r == '0) ? '0 : acc_r)
                  | ({{(MAX_NODES-1){1'b0}}, adj_rd[d_j_r]} << d_i_r);

  // Next order position: forward to the end, then backward to the start
  always_comb begin
    adv_state = ST_POS;
    adv_pos   = pos_r;
    adv_bwd   = bwd_r;
    if (!bwd_r) begin
      if (pos_r == nm1_r) begin
        adv_bwd = 1'b1;
      end else begin
        adv_pos = pos_r + IDX_W'(1);
      end
    end else if (pos_r == '0) begin
      adv_state = ST_OUT;
    end else begin
      adv_pos = pos_r - IDX_W'(1);
    end
  end

  // Sequencer and memory port control
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    nm1_nxt    = nm1_r;
    mask_nxt   = mask_r;
    bwd_nxt    = bwd_r;
    pos_nxt    = pos_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    pm_nxt     = pm_r;
    acc_nxt    = acc_r;
    d_vld_nxt  = 1'b0;
    d_i_nxt    = d_i_r;
    d_j_nxt    = d_j_r;
    o_vld_nxt  = 1'b0;
    o_j_nxt    = o_j_r;
    o_last_nxt = o_last_r;

    adj_ra  = i_r;
    topo_ra = pos_r;
    sel_ra  = j_r;

    adj_we  = 1'b0;
    adj_wa  = cmd_index;
    adj_wd  = cmd_row_bits;
    topo_we = 1'b0;
    topo_wa = cmd_index;
    topo_wd = cmd_ordered_node;
    par_we  = 1'b0;
    col_wa  = d_j_r;
    col_wd  = col_nxt;
    anc_we  = 1'b0;
    anc_wa  = d_j_r;
    anc_wd  = col_nxt;
    desc_we = 1'b0;
    desc_wa = d_i_r;
    desc_wd = adj_rd & mask_r;

    // Column gather: parents of node d_j, one row per transfer from adj_mem
    if (d_vld_r) begin
      if (d_i_r == nm1_r) begin
        par_we = 1'b1;
        anc_we = 1'b1;
      end else begin
        acc_nxt = col_nxt;
      end
      if (d_j_r == '0) begin
        desc_we = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          unique case (cmd_opcode)
            OP_LOAD_ROW:   adj_we  = 1'b1;
            OP_LOAD_ORDER: topo_we = 1'b1;
            OP_COMPUTE: begin
              n_nxt     = node_num;
              nm1_nxt   = IDX_W'(node_num - NUM_W'(1));
              mask_nxt  = {MAX_NODES{1'b1}} >> (NUM_W'(MAX_NODES) - node_num);
              i_nxt     = '0;
              j_nxt     = '0;
              pos_nxt   = '0;
              bwd_nxt   = 1'b0;
              state_nxt = ST_PAR;
            end
            default: ;
          endcase
        end
      end
      ST_PAR: begin
        d_vld_nxt = 1'b1;
        d_i_nxt   = i_r;
        d_j_nxt   = j_r;
        if (i_r == nm1_r) begin
          i_nxt = '0;
          if (j_r == nm1_r) begin
            pos_nxt   = '0;
            bwd_nxt   = 1'b0;
            state_nxt = ST_POS;
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      ST_POS: begin
        state_nxt = ST_KEY;
      end
      ST_KEY: begin
        // Skip positions whose node is out of use
        if ({1'b0, topo_rd} >= n_r) begin
          state_nxt = adv_state;
          pos_nxt   = adv_pos;
          bwd_nxt   = adv_bwd;
          j_nxt     = '0;
        end else begin
          k_nxt     = topo_rd;
          sel_ra    = topo_rd;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        pm_nxt    = bwd_r ? desc_rd : par_rd;
        acc_nxt   = set_rd;
        sel_ra    = '0;
        i_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        acc_nxt = scan_acc;
        if (i_r == nm1_r) begin
          if (bwd_r) begin
            desc_we = 1'b1;
            desc_wa = k_r;
            desc_wd = scan_acc;
          end else begin
            anc_we = 1'b1;
            anc_wa = k_r;
            anc_wd = scan_acc;
          end
          state_nxt = adv_state;
          pos_nxt   = adv_pos;
          bwd_nxt   = adv_bwd;
          j_nxt     = '0;
        end else begin
          sel_ra = i_r + IDX_W'(1);
          i_nxt  = i_r + IDX_W'(1);
        end
      end
      ST_OUT: begin
        o_vld_nxt  = 1'b1;
        o_j_nxt    = j_r;
        o_last_nxt = (j_r == nm1_r);
        if (j_r == nm1_r) begin
          state_nxt = ST_IDLE;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory writes and registered reads
  always_ff @(posedge clk) begin
    if (adj_we)  adj_mem[adj_wa]   <= adj_wd;
    if (topo_we) topo_mem[topo_wa] <= topo_wd;
    if (par_we)  par_mem[col_wa]   <= col_wd;
    if (anc_we)  anc_mem[anc_wa]   <= anc_wd;
    if (desc_we) desc_mem[desc_wa] <= desc_wd;
    adj_rd  <= adj_mem[adj_ra];
    topo_rd <= topo_mem[topo_ra];
    par_rd  <= par_mem[sel_ra];
    anc_rd  <= anc_mem[sel_ra];
    desc_rd <= desc_mem[sel_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      d_vld_r <= d_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    nm1_r    <= nm1_nxt;
    mask_r   <= mask_nxt;
    bwd_r    <= bwd_nxt;
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    pm_r     <= pm_nxt;
    acc_r    <= acc_nxt;
    d_i_r    <= d_i_nxt;
    d_j_r    <= d_j_nxt;
    o_j_r    <= o_j_nxt;
    o_last_r <= o_last_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    res.vld        = o_vld_r;
    res.node       = o_j_r;
    res.parent     = par_rd;
    res.ancestor   = anc_rd;
    res.descendant = desc_rd;
    res.last       = o_last_r;
  end

endmodule

[sv/dag_ancestor_descendant_closure.sv]
// Channel   | Ports                                      | Transfer
// ----------+--------------------------------------------+------------------------------
// command   | start, busy, in_opcode, in_index,          | start high while busy low
//           | in_row_bits, in_ordered_node               |
// result    | out_strobe, out_node, out_*_mask,          | out_strobe high, one cycle,
//           | out_*_count, out_last                      | no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata,      | psel, penable, pwrite, pready
//           | prdata, pready                             |
//
// Row and order loads leave busy low.
// A compute with n nodes in use keeps busy high through an n*n column gather over the
// adjacency memory, a forward and a backward walk of n positions, each position not
// skipped with one closure row read per cycle, and the result output.
// Results come out one per cycle, node 0 first, and cannot be stalled; the last one
// passes the output register after busy is low. Reset clears the sequencer, sets node_count to 64.
module dag_ancestor_descendant_closure (
  input  logic                            clk,
  input  logic                            rst_n,
  // command
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_opcode,
  input  logic [dagc_pkg::IDX_W-1:0]      in_index,
  input  logic [dagc_pkg::MAX_NODES-1:0]  in_row_bits,
  input  logic [dagc_pkg::IDX_W-1:0]      in_ordered_node,
  // results
  output logic                            out_strobe,
  output logic [dagc_pkg::IDX_W-1:0]      out_node,
  output logic [dagc_pkg::MAX_NODES-1:0]  out_parent_mask,
  output logic [dagc_pkg::CNT_W-1:0]      out_parent_count,
  output logic [dagc_pkg::MAX_NODES-1:0]  out_ancestor_mask,
  output logic [dagc_pkg::CNT_W-1:0]      out_ancestor_count,
  output logic [dagc_pkg::MAX_NODES-1:0]  out_descendant_mask,
  output logic [dagc_pkg::CNT_W-1:0]      out_descendant_count,
  output logic                            out_last,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import dagc_pkg::*;

  logic [NUM_W-1:0]     node_count_r;
  logic [NUM_W-1:0]     node_num;
  logic                 cmd_vld;
  logic                 cfg_wr;
  res_t                 res;

  logic                 strobe_r;
  logic [IDX_W-1:0]     node_r;
  logic [MAX_NODES-1:0] par_mask_r, anc_mask_r, desc_mask_r;
  logic [CNT_W-1:0]     par_cnt_r, anc_cnt_r, desc_cnt_r;
  logic                 last_r;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
      node_count_r <= pwdata[NUM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-NUM_W){1'b0}}, node_count_r}
                                               : '0;

  // Nodes in use, clamped to 1..MAX_NODES
  always_comb begin
    if (node_count_r == '0) begin
      node_num = NUM_W'(1);
    end else if (node_count_r > NUM_W'(MAX_NODES)) begin
      node_num = NUM_W'(MAX_NODES);
    end else begin
      node_num = node_count_r;
    end
  end

  assign cmd_vld = start & ~busy;

  dagc_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_vld          (cmd_vld),
    .cmd_opcode       (in_opcode),
    .cmd_index        (in_index),
    .cmd_row_bits     (in_row_bits),
    .cmd_ordered_node (in_ordered_node),
    .node_num         (node_num),
    .busy             (busy),
    .res              (res)
  );

  // Output stage: counts formed here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= res.node;
    par_mask_r  <= res.parent;
    anc_mask_r  <= res.ancestor;
    desc_mask_r <= res.descendant;
    par_cnt_r   <= sat_popcount(res.parent);
    anc_cnt_r   <= sat_popcount(res.ancestor);
    desc_cnt_r  <= sat_popcount(res.descendant);
    last_r      <= res.last;
  end

  assign out_strobe           = strobe_r;
  assign out_node             = node_r;
  assign out_parent_mask      = par_mask_r;
  assign out_parent_count     = par_cnt_r;
  assign out_ancestor_mask    = anc_mask_r;
  assign out_ancestor_count   = anc_cnt_r;
  assign out_descendant_mask  = desc_mask_r;
  assign out_descendant_count = desc_cnt_r;
  assign out_last             = last_r;

endmodule

[tb/dag_ancestor_descendant_closure_tb.sv]
module dag_ancestor_descendant_closure_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dagc_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

  // One command transfer
  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_W-1:0]     idx;
    logic [MAX_NODES-1:0] row;
    logic [IDX_W-1:0]     onode;
  } graph_cmd_t;

  // One closure result, in port order
  typedef struct packed {
    logic [IDX_W-1:0]     node;
    logic [MAX_NODES-1:0] parent;
    logic [CNT_W-1:0]     parent_cnt;
    logic [MAX_NODES-1:0] ancestor;
    logic [CNT_W-1:0]     ancestor_cnt;
    logic [MAX_NODES-1:0] descendant;
    logic [CNT_W-1:0]     descendant_cnt;
    logic                 is_last;
  } closure_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_opcode;
  logic [IDX_W-1:0]     in_index;
  logic [MAX_NODES-1:0] in_row_bits;
  logic [IDX_W-1:0]     in_ordered_node;
  logic                 out_strobe;
  logic [IDX_W-1:0]     out_node;
  logic [MAX_NODES-1:0] out_parent_mask;
  logic [CNT_W-1:0]     out_parent_count;
  logic [MAX_NODES-1:0] out_ancestor_mask;
  logic [CNT_W-1:0]     out_ancestor_count;
  logic [MAX_NODES-1:0] out_descendant_mask;
  logic [CNT_W-1:0]     out_descendant_count;
  logic                 out_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  dag_ancestor_descendant_closure DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_index             (in_index),
    .in_row_bits          (in_row_bits),
    .in_ordered_node      (in_ordered_node),
    .out_strobe           (out_strobe),
    .out_node             (out_node),
    .out_parent_mask      (out_parent_mask),
    .out_parent_count     (out_parent_count),
    .out_ancestor_mask    (out_ancestor_mask),
    .out_ancestor_count   (out_ancestor_count),
    .out_descendant_mask  (out_descendant_mask),
    .out_descendant_count (out_descendant_count),
    .out_last             (out_last),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Graph store mirror and configuration
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [IDX_W-1:0]     order_mem [MAX_NODES];
  logic [NUM_W-1:0]     node_count_cfg = NODE_COUNT_RST;

  graph_cmd_t pending_cmds [$];
  closure_t   expected_closures [$];
  graph_cmd_t cur_cmd;
  bit         cmd_taken = 1'b0;
  int         gap_left = 0;
  int         calm_left = 0;
  int         issued_cnt = 0;
  int         taken_cnt = 0;
  int         item_cnt = 0;
  int         err_cnt = 0;
  bit         row_done [MAX_NODES];
  bit         order_done [MAX_NODES];

  function automatic int eff_nodes(input logic [NUM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_NODES) return MAX_NODES;
    return int'(v);
  endfunction

  function automatic logic [MAX_NODES-1:0] node_mask(input int n);
    if (n >= MAX_NODES) return {MAX_NODES{1'b1}};
    return (MAX_NODES'(1) << n) - MAX_NODES'(1);
  endfunction

  // Distinct members of a set, saturated at the count field's range
  function automatic logic [CNT_W-1:0] set_size(input logic [MAX_NODES-1:0] v);
    int c;
    c = 0;
    for (int i = 0; i < MAX_NODES; i++) c += v[i];
    return (c > (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(c);
  endfunction

  // Apply one accepted command; a compute queues one closure per node in use
  function automatic void predict_closures(input graph_cmd_t c);
    int                   n;
    int                   k;
    logic [MAX_NODES-1:0] keep;
    logic [MAX_NODES-1:0] acc;
    logic [MAX_NODES-1:0] kids;
    logic [MAX_NODES-1:0] par [MAX_NODES];
    logic [MAX_NODES-1:0] anc [MAX_NODES];
    logic [MAX_NODES-1:0] des [MAX_NODES];
    closure_t             r;
    case (c.op)
      OP_LOAD_ROW: begin
        adj_mem[c.idx] = c.row;
      end
      OP_LOAD_ORDER: begin
        order_mem[c.idx] = c.onode;
      end
      OP_COMPUTE: begin
        n = eff_nodes(node_count_cfg);
        keep = node_mask(n);
        // direct parents seed the ancestors, direct children the descendants
        for (int j = 0; j < n; j++) begin
          par[j] = '0;
          for (int i = 0; i < n; i++) begin
            if (adj_mem[i][j]) par[j][i] = 1'b1;
          end
          anc[j] = par[j];
        end
        for (int i = 0; i < n; i++) des[i] = adj_mem[i] & keep;
        // forward walk over the order; out-of-range entries skipped
        for (int pos = 0; pos < n; pos++) begin
          k = order_mem[pos];
          if (k >= n) continue;
          acc = anc[k];
          for (int i = 0; i < n; i++) begin
            if (par[k][i]) acc |= anc[i];
          end
          anc[k] = acc;
        end
        // backward walk
        for (int pos = n - 1; pos >= 0; pos--) begin
          k = order_mem[pos];
          if (k >= n) continue;
          kids = des[k];
          acc = kids;
          for (int i = 0; i < n; i++) begin
            if (kids[i]) acc |= des[i];
          end
          des[k] = acc;
        end
        for (int j = 0; j < n; j++) begin
          r.node           = IDX_W'(j);
          r.parent         = par[j];
          r.parent_cnt     = set_size(par[j]);
          r.ancestor       = anc[j];
          r.ancestor_cnt   = set_size(anc[j]);
          r.descendant     = des[j];
          r.descendant_cnt = set_size(des[j]);
          r.is_last        = (j + 1 == n);
          expected_closures = {expected_closures, r};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string fmt_closure(input closure_t r);
    return $sformatf("node %0d par %h/%0d anc %h/%0d desc %h/%0d last %0b",
                     r.node, r.parent, r.parent_cnt, r.ancestor, r.ancestor_cnt,
                     r.descendant, r.descendant_cnt, r.is_last);
  endfunction

  function automatic void log_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Gap after a transfer: mostly none or short, a few long, with calm stretches
  function automatic int draw_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Command driver: changes at the falling edge, holds until the transfer
  always @(negedge clk) begin
    if (rst_n === 1'b1 && (start !== 1'b1 || cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        start           <= 1'b1;
        in_opcode       <= cur_cmd.op;
        in_index        <= cur_cmd.idx;
        in_row_bits     <= cur_cmd.row;
        in_ordered_node <= cur_cmd.onode;
        gap_left = draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result checker and command transfer tracking
  always @(posedge clk) begin : mon
    closure_t got;
    closure_t want;
    if (rst_n === 1'b1) begin
      if (out_strobe === 1'b1) begin
        got = {out_node, out_parent_mask, out_parent_count, out_ancestor_mask,
               out_ancestor_count, out_descendant_mask, out_descendant_count, out_last};
        if (expected_closures.size() == 0) begin
          log_mismatch({"unexpected result: ", fmt_closure(got)});
        end else begin
          want = expected_closures.pop_front();
          if (got !== want) begin
            log_mismatch({"closure mismatch\n  expected ", fmt_closure(want),
                          "\n  actual   ", fmt_closure(got)});
          end
        end
      end
      cmd_taken = (start === 1'b1) && (busy === 1'b0);
      if (cmd_taken) begin
        taken_cnt++;
        predict_closures(cur_cmd);
      end
    end
  end

  // Stimulus helpers
  function automatic void queue_cmd(input logic [1:0] op, input int idx,
                                    input logic [MAX_NODES-1:0] row, input int onode);
    graph_cmd_t c;
    c.op    = op;
    c.idx   = IDX_W'(idx);
    c.row   = row;
    c.onode = IDX_W'(onode);
    pending_cmds = {pending_cmds, c};
    issued_cnt++;
    if (op != OP_UNUSED) item_cnt++;
    if (op == OP_LOAD_ROW) row_done[c.idx] = 1'b1;
    if (op == OP_LOAD_ORDER) order_done[c.idx] = 1'b1;
  endfunction

  function automatic logic [MAX_NODES-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // Compute, after filling any row or order entry in use that was never loaded
  function automatic void queue_compute(input int n);
    for (int i = 0; i < n; i++) begin
      if (!row_done[i]) queue_cmd(OP_LOAD_ROW, i, '0, 0);
      if (!order_done[i]) queue_cmd(OP_LOAD_ORDER, i, '0, i);
    end
    queue_cmd(OP_COMPUTE, $urandom_range(0, 63), rand_row(), $urandom_range(0, 63));
  endfunction

  // Random DAG over n nodes with its topological order; junk from bit n up at times
  function automatic void load_random_graph(input int n, input int dens);
    int                   perm [MAX_NODES];
    int                   j;
    int                   t;
    bit                   orders_first;
    logic [MAX_NODES-1:0] keep;
    logic [MAX_NODES-1:0] row;
    keep = node_mask(n);
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    orders_first = $urandom_range(0, 1);
    if (orders_first) begin
      for (int a = 0; a < n; a++) queue_cmd(OP_LOAD_ORDER, a, rand_row(), perm[a]);
    end
    for (int a = 0; a < n; a++) begin
      row = '0;
      for (int b = a + 1; b < n; b++) begin
        if ($urandom_range(0, 99) < dens) row[perm[b]] = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) row |= rand_row() & ~keep;
      queue_cmd(OP_LOAD_ROW, perm[a], row, $urandom_range(0, 63));
    end
    if (!orders_first) begin
      for (int a = 0; a < n; a++) queue_cmd(OP_LOAD_ORDER, a, rand_row(), perm[a]);
    end
  endfunction

  // Broken graphs: random rows (cycles), bad order entries, slots from n-1 up, opcode 3
  function automatic void add_noise(input int n);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: queue_cmd(OP_LOAD_ROW, $urandom_range(0, n - 1), rand_row(), $urandom_range(0, 63));
        1: queue_cmd(OP_LOAD_ORDER, $urandom_range(0, n - 1), rand_row(),
                     $urandom_range(0, 63));
        2: begin
          queue_cmd(OP_LOAD_ROW, $urandom_range(n - 1, 63), rand_row(), 0);
          queue_cmd(OP_LOAD_ORDER, $urandom_range(n - 1, 63), '0, $urandom_range(0, 63));
        end
        default: queue_cmd(OP_UNUSED, $urandom_range(0, 63), rand_row(),
                           $urandom_range(0, 63));
      endcase
    end
  endfunction

  // Wait until every command is taken and every closure has arrived
  task automatic wait_idle();
    do @(posedge clk);
    while (taken_cnt != issued_cnt || busy !== 1'b0 || expected_closures.size() != 0);
  endtask

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register write while idle, then read back
  task automatic set_node_count(input logic [NUM_W-1:0] v);
    logic [31:0] rd;
    wait_idle();
    repeat (8) @(posedge clk);
    apb_xfer(1'b1, 32'(v), rd);
    node_count_cfg = v;
    apb_xfer(1'b0, '0, rd);
    if (rd[NUM_W-1:0] !== v) begin
      log_mismatch($sformatf("node_count readback %0d, wrote %0d", rd[NUM_W-1:0], v));
    end
  endtask

  initial begin : stim
    int nc;
    int n;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_LOAD_ROW;
    in_index        = '0;
    in_row_bits     = '0;
    in_ordered_node = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: diamond with junk from bit n up, then broken order and cycles
    set_node_count(NUM_W'(6));
    queue_cmd(OP_LOAD_ROW, 0, 64'h8000_0000_0000_0006, 0);
    queue_cmd(OP_LOAD_ROW, 1, 64'h0000_0000_0000_0008, 0);
    queue_cmd(OP_LOAD_ROW, 2, 64'h0000_0000_0000_0008, 0);
    queue_cmd(OP_LOAD_ROW, 3, 64'h0000_0000_0000_0010, 0);
    queue_cmd(OP_LOAD_ROW, 4, 64'hFFFF_FFFF_FFFF_FFC0, 0);
    queue_cmd(OP_LOAD_ROW, 5, '0, 0);
    for (int i = 0; i < 6; i++) queue_cmd(OP_LOAD_ORDER, i, '0, i);
    queue_compute(6);
    queue_cmd(OP_UNUSED, 63, {MAX_NODES{1'b1}}, 63);
    // self-loop and parent of all; order entry out of range
    queue_cmd(OP_LOAD_ROW, 5, {MAX_NODES{1'b1}}, 0);
    queue_cmd(OP_LOAD_ORDER, 5, '0, 63);
    queue_compute(6);
    // cycle 0 -> 1 -> 3 -> 0
    queue_cmd(OP_LOAD_ORDER, 5, '0, 5);
    queue_cmd(OP_LOAD_ROW, 3, 64'h0000_0000_0000_0001, 0);
    queue_compute(6);
    // top slot of the store, outside the nodes in use
    queue_cmd(OP_LOAD_ROW, 63, {MAX_NODES{1'b1}}, 0);
    queue_cmd(OP_LOAD_ORDER, 63, {MAX_NODES{1'b1}}, 63);
    queue_cmd(OP_UNUSED, 0, '0, 0);
    queue_compute(6);

    // Extremes of node_count: zero acts as one, 64, above 64
    set_node_count(NUM_W'(0));
    load_random_graph(1, 0);
    queue_compute(1);
    queue_cmd(OP_LOAD_ROW, 0, rand_row() | 64'h1, 0);
    queue_compute(1);
    set_node_count(NUM_W'(1));
    queue_cmd(OP_LOAD_ROW, 0, rand_row() & ~64'h1, 0);
    queue_compute(1);
    set_node_count(NUM_W'(MAX_NODES));
    load_random_graph(MAX_NODES, 4);
    queue_compute(MAX_NODES);
    // full row on node 0 drives the descendant count into saturation
    set_node_count({NUM_W{1'b1}});
    queue_cmd(OP_LOAD_ROW, 0, {MAX_NODES{1'b1}}, 0);
    queue_compute(MAX_NODES);

    // Random phases, mostly small graphs
    while (item_cnt < 280) begin
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      set_node_count(NUM_W'(nc));
      n = eff_nodes(NUM_W'(nc));
      repeat ($urandom_range(1, 3)) begin
        if (item_cnt < 280) begin
          load_random_graph(n, $urandom_range(15, 60));
          queue_compute(n);
          if ($urandom_range(0, 1) == 1) begin
            add_noise(n);
            queue_compute(n);
          end
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_closures.size() == 0) begin
      $display("dag_ancestor_descendant_closure_tb: PASS");
    end else begin
      $display("dag_ancestor_descendant_closure_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("dag_ancestor_descendant_closure_tb: FAIL");
    $finish;
  end

endmodule
